[hdl/tcbd_pkg.sv]
// Shared types, constants and lookup tables of the table-driven block decryptor.
package tcbd_pkg;

	localparam int ROUNDS       = 17;
	localparam int BYTES        = 16;
	localparam int SPAN         = 256;
	localparam int WORDS        = 4;
	localparam int KEY_WORDS    = ROUNDS * WORDS;
	localparam int ROUND_W      = 5;
	localparam int TBL_DEPTH    = ROUNDS * SPAN;
	localparam int TBL_ROW_W    = 13;
	localparam int NUM_KEYS_DEF = 101;

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

	// action codes
	localparam logic [1:0] ACT_LOAD_TABLE = 2'd0;
	localparam logic [1:0] ACT_LOAD_KEY   = 2'd1;
	localparam logic [1:0] ACT_DECRYPT    = 2'd2;

	// byte positions taken by the middle rounds, four per output word
	localparam logic [3:0] SHIFT_PICK [BYTES] = '{
		4'd0, 4'd7, 4'd10, 4'd13, 4'd1, 4'd4, 4'd11, 4'd14,
		4'd2, 4'd5, 4'd8, 4'd15, 4'd3, 4'd6, 4'd9, 4'd12
	};

	typedef struct packed {
		logic [1:0]  action;
		logic [16:0] address;
		logic [31:0] load_word;
		logic [6:0]  key_slot;
		logic [63:0] cipher_low;
		logic [63:0] cipher_high;
	} request_t;

	typedef struct packed {
		logic [63:0] plain_low;
		logic [63:0] plain_high;
	} result_t;

	typedef struct packed {
		logic                 en;
		logic [TBL_ROW_W-1:0] row;
		logic [31:0]          word;
	} lane_wr_t;

	typedef struct packed {
		logic               en;
		logic [ROUND_W-1:0] rnd;
	} lane_rd_t;

endpackage

[hdl/tcbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/tcbd_lane.sv]
// One byte lane: the round-table bank of one byte position and its lookup.
module tcbd_lane
	import tcbd_pkg::*;
(
	input  logic        clk,
	input  lane_wr_t    wr,
	input  lane_rd_t    rd,
	input  logic [7:0]  byte_val,
	output logic [31:0] word
);

	logic [TBL_ROW_W-1:0] rd_row;

	// each round owns 256 consecutive rows of the bank
	assign rd_row = {rd.rnd, byte_val};

	tcbd_ram #(
		.WIDTH (32),
		.DEPTH (TBL_DEPTH),
		.AW    (TBL_ROW_W)
	) u_bank (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.row),
		.wdata (wr.word),
		.re    (rd.en),
		.raddr (rd_row),
		.rdata (word)
	);

endmodule

[hdl/tcbd_merge.sv]
// Merge stage: XOR the sixteen lane words and four subkeys into the next block.
module tcbd_merge
	import tcbd_pkg::*;
(
	input  logic [31:0]  lane_word [BYTES],
	input  logic [31:0]  key_word [WORDS],
	input  logic         shifted,
	output logic [127:0] blk
);

	always_comb begin
		logic [31:0] acc;
		logic [3:0]  sel;
		blk = '0;
		for (int i = 0; i < WORDS; i++) begin
			acc = key_word[i];
			for (int j = 0; j < 4; j++) begin
				sel = shifted ? SHIFT_PICK[i*4 + j] : 4'(i*4 + j);
				acc ^= lane_word[sel];
			end
			blk[i*32 +: 32] = acc;
		end
	end

endmodule

[hdl/table_cipher_block_decrypt_core.sv]
// Top level of the table-driven 128-bit block decryptor.
//
// Each request either writes one 32-bit word into the round-table store
// (action 0), writes one word into the subkey store (action 1), or decrypts
// one 16-byte block (action 2); action 3 is dropped. Loads finish in the cycle
// they are accepted and give no result. A decrypt runs 17 rounds at one round
// per cycle: sixteen byte lanes each own the table bank of one byte position
// and look up their byte every cycle, four subkey banks deliver the round's
// subkeys at the same time, and the merge stage XORs them into the next block,
// whose bytes address the next round's lookups directly. The loop through the
// lane banks' registered read port sets the pace: the result register loads
// once all 17 lookup rounds and the closing merge in the done state are
// through, later if the previous result has not been taken, and the next
// request is taken in the cycle after that. A finished result waits in the
// output register while new requests are accepted. Table loads at word
// addresses of 69632 and above, and subkey loads at addresses of NUM_KEYS*68
// and above, are ignored; a key index of NUM_KEYS or more selects the last
// key. Reading a store word that was never written yields an undefined block.
module table_cipher_block_decrypt_core
	import tcbd_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_ready,
	input  request_t request,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result
);

	localparam int KEY_ROWS  = NUM_KEYS * ROUNDS;
	localparam int KEY_DEPTH = NUM_KEYS * KEY_WORDS;
	localparam int ROW_W     = $clog2(KEY_ROWS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [ROUND_W-1:0] rnd_q;
	logic [ROUND_W-1:0] drnd_q;
	logic [127:0]       blk_q;
	logic [ROW_W-1:0]   kbase_q;

	logic         accept;
	logic         start;
	logic         tbl_load;
	logic         key_load;
	logic         out_free;
	logic [7:0]   key_ext;
	logic [7:0]   key_c;
	logic [12:0]  kbase_full;
	logic [ROW_W-1:0] key_row;
	logic [127:0] merged;
	logic [127:0] src_blk;
	logic         shifted;
	lane_rd_t     rd;
	logic [31:0]  lane_word [BYTES];
	logic [31:0]  key_word [WORDS];

	assign request_ready = (state_q == ST_IDLE);
	assign accept        = request_valid && request_ready;
	assign start         = accept && (request.action == ACT_DECRYPT);
	assign tbl_load      = accept && (request.action == ACT_LOAD_TABLE)
		&& (request.address[16:12] < ROUND_W'(ROUNDS));
	assign key_load      = accept && (request.action == ACT_LOAD_KEY)
		&& (request.address < 17'(KEY_DEPTH));
	assign out_free      = !result_valid || result_ready;

	// clamp the key index, then find its first subkey row
	assign key_ext    = {1'b0, request.key_slot};
	assign key_c      = (key_ext > 8'(NUM_KEYS - 1)) ? 8'(NUM_KEYS - 1) : key_ext;
	assign kbase_full = 13'(key_c) * 13'(ROUNDS);
	assign key_row    = kbase_q + ROW_W'(rnd_q);

	// round zero looks up the ciphertext, later rounds the freshly merged block
	assign src_blk = (rnd_q == '0) ? blk_q : merged;
	assign shifted = (drnd_q >= ROUND_W'(2)) && (drnd_q <= ROUND_W'(ROUNDS - 2));

	assign rd.en  = (state_q == ST_RUN);
	assign rd.rnd = rnd_q;

	for (genvar p = 0; p < BYTES; p++) begin : g_lane
		lane_wr_t wr;

		assign wr.en   = tbl_load && (request.address[11:8] == 4'(p));
		assign wr.row  = {request.address[16:12], request.address[7:0]};
		assign wr.word = request.load_word;

		tcbd_lane u_lane (
			.clk      (clk),
			.wr       (wr),
			.rd       (rd),
			.byte_val (src_blk[p*8 +: 8]),
			.word     (lane_word[p])
		);
	end

	// subkey banks: word i of every round sits in bank i
	for (genvar i = 0; i < WORDS; i++) begin : g_key
		tcbd_ram #(
			.WIDTH (32),
			.DEPTH (KEY_ROWS),
			.AW    (ROW_W)
		) u_key (
			.clk   (clk),
			.we    (key_load && (request.address[1:0] == 2'(i))),
			.waddr (ROW_W'(request.address[16:2])),
			.wdata (request.load_word),
			.re    (rd.en),
			.raddr (key_row),
			.rdata (key_word[i])
		);
	end

	tcbd_merge u_merge (
		.lane_word (lane_word),
		.key_word  (key_word),
		.shifted   (shifted),
		.blk       (merged)
	);

	// control: hold state and the result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rnd_q        <= '0;
			drnd_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			// in the done state a taken result is replaced below
			if (result_valid && result_ready && (state_q != ST_DONE)) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						rnd_q   <= '0;
					end
				end
				ST_RUN: begin
					drnd_q <= rnd_q;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_DONE;
					end else begin
						rnd_q <= rnd_q + ROUND_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
						rnd_q        <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: capture the block and key base, load the result
	always_ff @(posedge clk) begin
		if (start) begin
			blk_q   <= {request.cipher_high, request.cipher_low};
			kbase_q <= ROW_W'(kbase_full);
		end
		if ((state_q == ST_DONE) && out_free) begin
			result.plain_low  <= merged[63:0];
			result.plain_high <= merged[127:64];
		end
	end

`ifndef SYNTH
	a_round_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && rnd_q != LAST_ROUND) |=> (rnd_q == $past(rnd_q) + ROUND_W'(1)))
		else $error("round counter did not advance");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final round");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= LAST_ROUND)
		else $error("round counter out of range");

	a_key_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (32'(key_row) < 32'(KEY_ROWS)))
		else $error("subkey row out of range");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for the table-driven block decryptor: directed and random requests.
`timescale 1ns / 1ps

module testbench;
	import tcbd_pkg::*;

	localparam int NUM_KEYS     = NUM_KEYS_DEF;
	localparam int TABLE_WORDS  = ROUNDS * BYTES * SPAN;
	localparam int KEY_TOTAL    = NUM_KEYS * KEY_WORDS;
	localparam int RANDOM_ITEMS = 580;
	// the last requests of the run go out with no idling on either side
	localparam int CALM_TAIL    = 150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int END_CYCLES   = 40;
	// decrypts use only the first, middle and last subkey sets
	localparam int LIVE_MID     = NUM_KEYS / 2;

	// the one action code the package leaves unnamed; the block drops it
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// byte positions read by the middle rounds, nibble i holds the position for
	// table slot i (slots 4w..4w+3 build output word w)
	localparam logic [63:0] MIX_PICK = 64'hC963_F852_EB41_DA70;

	typedef struct packed {
		logic     drain;
		request_t req;
	} pending_t;

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	logic     request_valid = 1'b0;
	logic     request_ready;
	request_t request       = '0;
	logic     result_valid;
	logic     result_ready  = 1'b0;
	result_t  result;

	// bench copy of both stores, updated as each request is accepted
	bit [31:0] round_table [TABLE_WORDS];
	bit [31:0] subkey_words [KEY_TOTAL];

	// bytes entering round r are always 0 or basis[r]; basis[ROUNDS] covers the
	// plaintext. Table words and subkeys of round r keep every byte 0 or
	// basis[r+1], so the XOR of a round stays inside that set and a decrypt only
	// reads the two table rows per position that the fill writes.
	logic [7:0] basis [ROUNDS + 1];

	pending_t pending_requests [$];
	result_t  expected_plain [$];
	result_t  oldest_plain;

	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	int unsigned error_count;

	table_cipher_block_decrypt_core #(
		.NUM_KEYS(NUM_KEYS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request      (request),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run all 17 rounds on the bench copy of the stores. Rounds 0, 1 and 16
	// take each byte group straight across; the middle rounds take the bytes
	// in the shifted pattern. Each round ends by laying the four new words back
	// down as bytes, least significant first.
	function automatic result_t decrypt_block(input logic [6:0] key_sel,
			input logic [63:0] lo, input logic [63:0] hi);
		logic [7:0]  blk [BYTES];
		logic [31:0] acc [WORDS];
		int unsigned kbase;
		int unsigned pos;
		result_t     plain;
		// clamp a key index past the last stored set
		kbase = ((key_sel >= NUM_KEYS) ? NUM_KEYS - 1 : key_sel) * KEY_WORDS;
		for (int i = 0; i < 8; i++) begin
			blk[i]     = lo[8*i +: 8];
			blk[i + 8] = hi[8*i +: 8];
		end
		for (int rnd = 0; rnd < ROUNDS; rnd++) begin
			for (int w = 0; w < WORDS; w++) begin
				acc[w] = subkey_words[kbase + rnd * WORDS + w];
				for (int j = 0; j < 4; j++) begin
					if (rnd >= 2 && rnd < ROUNDS - 1)
						pos = MIX_PICK[4 * (w * 4 + j) +: 4];
					else
						pos = w * 4 + j;
					acc[w] ^= round_table[(rnd * BYTES + pos) * SPAN + blk[pos]];
				end
			end
			for (int i = 0; i < BYTES; i++)
				blk[i] = acc[i / 4][8 * (i % 4) +: 8];
		end
		for (int i = 0; i < 8; i++) begin
			plain.plain_low[8*i +: 8]  = blk[i];
			plain.plain_high[8*i +: 8] = blk[i + 8];
		end
		return plain;
	endfunction

	// A word whose bytes are each 0 or basis[idx].
	function automatic logic [31:0] space_word(input int unsigned idx);
		logic [31:0] w;
		for (int j = 0; j < 4; j++)
			w[8*j +: 8] = ($urandom_range(0, 1) == 1) ? basis[idx] : 8'h00;
		return w;
	endfunction

	// Half a ciphertext block whose bytes are each 0 or basis[0].
	function automatic logic [63:0] space_half();
		logic [63:0] h;
		for (int j = 0; j < 8; j++)
			h[8*j +: 8] = ($urandom_range(0, 1) == 1) ? basis[0] : 8'h00;
		return h;
	endfunction

	function automatic bit live_key(input int unsigned k);
		return (k == 0) || (k == LIVE_MID) || (k == NUM_KEYS - 1);
	endfunction

	function automatic int unsigned pick_live_key();
		int unsigned k;
		case ($urandom_range(0, 2))
			0: k = 0;
			1: k = LIVE_MID;
			default: k = NUM_KEYS - 1;
		endcase
		return k;
	endfunction

	// Rows a decrypt can reach get a word inside the next byte space, others noise.
	function automatic logic [31:0] table_word(input int unsigned rnd, input logic [7:0] b);
		return (b == 8'h00 || b == basis[rnd]) ? space_word(rnd + 1) : $urandom;
	endfunction

	// Subkeys of a live set stay inside the byte space of their round's output.
	function automatic logic [31:0] subkey_word(input int unsigned a);
		return live_key(a / KEY_WORDS) ? space_word((a % KEY_WORDS) / WORDS + 1)
			: $urandom;
	endfunction

	// Fill every field with noise so that fields a request does not use still toggle.
	function automatic request_t noise_request();
		request_t r;
		r.action      = 2'($urandom);
		r.address     = 17'($urandom);
		r.load_word   = $urandom;
		r.key_slot    = 7'($urandom);
		r.cipher_low  = {$urandom, $urandom};
		r.cipher_high = {$urandom, $urandom};
		return r;
	endfunction

	function automatic request_t load_request(input logic [1:0] act,
			input logic [16:0] addr, input logic [31:0] word);
		request_t r;
		r           = noise_request();
		r.action    = act;
		r.address   = addr;
		r.load_word = word;
		return r;
	endfunction

	function automatic request_t decrypt_request(input logic [6:0] key_sel,
			input logic [63:0] lo, input logic [63:0] hi);
		request_t r;
		r             = noise_request();
		r.action      = ACT_DECRYPT;
		r.key_slot    = key_sel;
		r.cipher_low  = lo;
		r.cipher_high = hi;
		return r;
	endfunction

	// A request marked drain is held back until every expected block has come out.
	task automatic push_request(input request_t r, input logic drain = 1'b0);
		pending_requests.push_back({drain, r});
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns MISMATCH %s", $time, what);
		error_count++;
	endtask

	// Request driver: update the bench stores or queue the expected block for
	// each accepted request, then hold, idle or present the next request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_valid <= 1'b0;
			request       <= '0;
			gap_left      <= 0;
		end else begin
			if (request_valid && request_ready) begin
				case (request.action)
					ACT_LOAD_TABLE: begin
						if (request.address < TABLE_WORDS)
							round_table[request.address] = request.load_word;
					end
					ACT_LOAD_KEY: begin
						if (request.address < KEY_TOTAL)
							subkey_words[request.address] = request.load_word;
					end
					ACT_DECRYPT: begin
						expected_plain.push_back(decrypt_block(request.key_slot,
							request.cipher_low, request.cipher_high));
					end
					default: begin
					end
				endcase
			end
			// a request still waiting is held with its payload untouched
			if (!request_valid || request_ready) begin
				if (gap_left != 0) begin
					request_valid <= 1'b0;
					gap_left      <= gap_left - 1;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].drain && expected_plain.size() != 0)) begin
					request       <= pending_requests[0].req;
					request_valid <= 1'b1;
					void'(pending_requests.pop_front());
					// idle for a burst after this request is taken
					if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
						gap_left <= $urandom_range(1, 7);
				end else begin
					request_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted block with the oldest expectation,
	// and stall the output in random bursts outside the calm tail.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_plain.size() == 0) begin
					report_mismatch($sformatf("block %h_%h with no decrypt pending",
						result.plain_high, result.plain_low));
				end else begin
					oldest_plain = expected_plain.pop_front();
					if (result.plain_low !== oldest_plain.plain_low)
						report_mismatch($sformatf("plain_low %h, want %h",
							result.plain_low, oldest_plain.plain_low));
					if (result.plain_high !== oldest_plain.plain_high)
						report_mismatch($sformatf("plain_high %h, want %h",
							result.plain_high, oldest_plain.plain_high));
				end
			end
			if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left   <= stall_left - 1;
			end else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
				result_ready <= 1'b0;
				stall_left   <= $urandom_range(0, 6);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when neither side has moved for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((request_valid && request_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		request_t    req;
		int unsigned counted;
		int unsigned pick;
		int unsigned pos;
		int unsigned k;
		int unsigned n;
		int unsigned addr;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [7:0]  b;

		// Ciphertext and plaintext bytes are 00 or FF; the bytes between rounds
		// use a random nonzero basis per round.
		basis[0]      = 8'hFF;
		basis[ROUNDS] = 8'hFF;
		for (int r = 1; r < ROUNDS; r++)
			basis[r] = 8'($urandom_range(1, 255));

		// Write every table row and live subkey that a decrypt can read.
		for (int r = 0; r < ROUNDS; r++) begin
			for (int p = 0; p < BYTES; p++) begin
				push_request(load_request(ACT_LOAD_TABLE,
					17'((r * BYTES + p) * SPAN), space_word(r + 1)));
				push_request(load_request(ACT_LOAD_TABLE,
					17'((r * BYTES + p) * SPAN + basis[r]), space_word(r + 1)));
			end
		end
		for (int a = 0; a < KEY_TOTAL; a++)
			if (live_key(a / KEY_WORDS))
				push_request(load_request(ACT_LOAD_KEY, 17'(a), subkey_word(a)));

		// Directed: extreme keys and blocks, key clamping, store edges,
		// ignored loads past either store and the unused action.
		push_request(decrypt_request(7'd0, '0, '0));
		push_request(decrypt_request(7'(NUM_KEYS - 1), '1, '1));
		push_request(decrypt_request(7'h7F, space_half(), space_half()));
		push_request(decrypt_request(7'(NUM_KEYS), space_half(), space_half()));
		push_request(load_request(ACT_LOAD_TABLE, 17'd0, {4{basis[1]}}));
		// wait out the blocks above; byte 0 of zero reads the word just loaded
		push_request(decrypt_request(7'd0, 64'hFFFF_FFFF_FFFF_FF00, space_half()),
			1'b1);
		push_request(load_request(ACT_LOAD_TABLE, 17'(TABLE_WORDS - 1), 32'h0));
		push_request(load_request(ACT_LOAD_TABLE, 17'(TABLE_WORDS), $urandom));
		push_request(load_request(ACT_LOAD_TABLE, 17'h1FFFF, $urandom));
		push_request(decrypt_request(7'(LIVE_MID), space_half(), space_half()));
		push_request(load_request(ACT_LOAD_KEY, 17'(KEY_TOTAL - 1), 32'hFFFF_FFFF));
		push_request(load_request(ACT_LOAD_KEY, 17'(KEY_TOTAL), $urandom));
		push_request(load_request(ACT_LOAD_KEY, 17'h1FFFF, $urandom));
		push_request(decrypt_request(7'h7F, space_half(), space_half()));
		push_request(load_request(ACT_LOAD_KEY, 17'd0, 32'h0));
		push_request(decrypt_request(7'd0, space_half(), space_half()));
		req        = '1;
		req.action = ACT_UNUSED;
		push_request(req);
		push_request(decrypt_request(7'(NUM_KEYS - 1), '0, '1));

		// Random part.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// mostly live keys, some past the end to exercise the clamp
				k = ($urandom_range(0, 6) == 0) ? $urandom_range(NUM_KEYS, 127)
					: pick_live_key();
				push_request(decrypt_request(7'(k), space_half(), space_half()),
					$urandom_range(0, 99) == 0);
				counted++;
			end else if (pick < 55) begin
				// any row of any round; reachable rows keep their byte space
				k   = $urandom_range(0, ROUNDS - 1);
				pos = $urandom_range(0, BYTES - 1);
				case ($urandom_range(0, 2))
					0: b = 8'h00;
					1: b = basis[k];
					default: b = 8'($urandom);
				endcase
				push_request(load_request(ACT_LOAD_TABLE,
					17'((k * BYTES + pos) * SPAN + b), table_word(k, b)));
				counted++;
			end else if (pick < 65) begin
				addr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, KEY_TOTAL - 1)
					: pick_live_key() * KEY_WORDS + $urandom_range(0, KEY_WORDS - 1);
				push_request(load_request(ACT_LOAD_KEY, 17'(addr), subkey_word(addr)));
				counted++;
			end else if (pick < 75) begin
				// rewrite a few subkeys of one set, then decrypt under that set
				k = pick_live_key();
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					addr = k * KEY_WORDS + $urandom_range(0, KEY_WORDS - 1);
					push_request(load_request(ACT_LOAD_KEY, 17'(addr), subkey_word(addr)));
				end
				if (k == NUM_KEYS - 1 && $urandom_range(0, 1) == 1)
					k = $urandom_range(NUM_KEYS, 127);
				push_request(decrypt_request(7'(k), space_half(), space_half()));
				counted += n + 1;
			end else if (pick < 85) begin
				// rewrite the first-round table word that the next block looks up
				lo  = space_half();
				hi  = space_half();
				pos = $urandom_range(0, BYTES - 1);
				b   = (pos < 8) ? lo[8*pos +: 8] : hi[8*(pos-8) +: 8];
				push_request(load_request(ACT_LOAD_TABLE, 17'(pos * SPAN + b),
					table_word(0, b)));
				push_request(decrypt_request(7'(pick_live_key()), lo, hi));
				counted += 2;
			end else if (pick < 90) begin
				push_request(load_request(ACT_LOAD_TABLE,
					17'($urandom_range(TABLE_WORDS, 17'h1FFFF)), $urandom));
				counted++;
			end else if (pick < 95) begin
				push_request(load_request(ACT_LOAD_KEY,
					17'($urandom_range(KEY_TOTAL, 17'h1FFFF)), $urandom));
				counted++;
			end else begin
				req        = noise_request();
				req.action = ACT_UNUSED;
				push_request(req);
				counted++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every request taken, then every expected block seen
		while (pending_requests.size() != 0 || request_valid || expected_plain.size() != 0)
			@(posedge clk);
		// leave room for any stray block the core might still emit
		repeat (END_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[table_cipher_block_decrypt_core.f]
hdl/tcbd_pkg.sv
hdl/tcbd_ram.sv
hdl/tcbd_lane.sv
hdl/tcbd_merge.sv
hdl/table_cipher_block_decrypt_core.sv
bench/testbench.sv
